// File: sv/elastic_disc_collision_resolve_unit_macros.svh
// Assertion macros for the disc collision resolver.
// Expects clk and rst in the scope of the module that uses them.
`ifndef ELASTIC_DISC_COLLISION_RESOLVE_UNIT_MACROS_SVH
`define ELASTIC_DISC_COLLISION_RESOLVE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define EDCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define EDCR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset
`define EDCR_ASSERT_RST(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: sv/edcr_pkg.sv
// Package of the disc collision resolver: field widths, status codes and
// the item record carried down the pipeline. No dependencies.
`default_nettype none

package edcr_pkg;

  localparam int POS_W     = 24;
  localparam int VEL_W     = 20;
  localparam int RAD_W     = 22;
  localparam int MASS_W    = 16;
  localparam int STAT_W    = 2;
  localparam int UNIT_FRAC = 20;

  localparam int D_W     = POS_W + 1;          // centre difference
  localparam int RS_W    = RAD_W + 1;          // radius sum
  localparam int DIST_W  = RS_W;               // distance when in contact
  localparam int SQ_IN_W = 2 * DIST_W;
  localparam int U_W     = UNIT_FRAC + 2;      // unit normal, Q2.20
  localparam int VN_W    = 25;                 // normal relative speed
  localparam int J_W     = VN_W + 2;           // exchanged normal speed
  localparam int MSUM_W  = MASS_W + 1;
  localparam int DEL_W   = 30;                 // rounded velocity change

  typedef enum logic [STAT_W-1:0] {
    ST_NONE       = 2'd0,
    ST_RESOLVED   = 2'd1,
    ST_COINCIDENT = 2'd2
  } edcr_status_t;

  typedef struct packed {
    edcr_status_t              status;
    logic signed [POS_W-1:0]   p1x;
    logic signed [POS_W-1:0]   p1y;
    logic signed [POS_W-1:0]   p2x;
    logic signed [POS_W-1:0]   p2y;
    logic signed [VEL_W-1:0]   v1x;
    logic signed [VEL_W-1:0]   v1y;
    logic signed [VEL_W-1:0]   v2x;
    logic signed [VEL_W-1:0]   v2y;
    logic [MASS_W-1:0]         m1;
    logic [MASS_W-1:0]         m2;
    logic [RS_W-1:0]           rs;
    logic signed [D_W-1:0]     dx;
    logic signed [D_W-1:0]     dy;
    logic [DIST_W-1:0]         ctr_dist;
    logic signed [POS_W-1:0]   sx;
    logic signed [POS_W-1:0]   sy;
    logic signed [U_W-1:0]     ux;
    logic signed [U_W-1:0]     uy;
    logic signed [VN_W-1:0]    vn;
    logic signed [J_W-1:0]     j1;
    logic signed [J_W-1:0]     j2;
  } edcr_item_t;

  typedef struct packed {
    edcr_status_t              status;
    logic signed [POS_W-1:0]   n1x;
    logic signed [POS_W-1:0]   n1y;
    logic signed [POS_W-1:0]   n2x;
    logic signed [POS_W-1:0]   n2y;
    logic signed [VEL_W-1:0]   w1x;
    logic signed [VEL_W-1:0]   w1y;
    logic signed [VEL_W-1:0]   w2x;
    logic signed [VEL_W-1:0]   w2y;
  } edcr_result_t;

endpackage

`default_nettype wire

// File: sv/edcr_ifs.sv
// Valid/ready channel interfaces of the disc collision resolver.
// Depends on edcr_pkg for the field widths.
`default_nettype none

interface edcr_pair_if import edcr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  first_pos_x;
  logic signed [POS_W-1:0]  first_pos_y;
  logic signed [POS_W-1:0]  second_pos_x;
  logic signed [POS_W-1:0]  second_pos_y;
  logic signed [VEL_W-1:0]  first_vel_x;
  logic signed [VEL_W-1:0]  first_vel_y;
  logic signed [VEL_W-1:0]  second_vel_x;
  logic signed [VEL_W-1:0]  second_vel_y;
  logic [RAD_W-1:0]         first_radius;
  logic [RAD_W-1:0]         second_radius;
  logic [MASS_W-1:0]        first_mass;
  logic [MASS_W-1:0]        second_mass;

  modport source (
    output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_radius, second_radius, first_mass, second_mass,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
           first_vel_x, first_vel_y, second_vel_x, second_vel_y,
           first_radius, second_radius, first_mass, second_mass,
    output ready
  );
endinterface

interface edcr_result_if import edcr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        contact_status;
  logic signed [POS_W-1:0]  new_first_pos_x;
  logic signed [POS_W-1:0]  new_first_pos_y;
  logic signed [POS_W-1:0]  new_second_pos_x;
  logic signed [POS_W-1:0]  new_second_pos_y;
  logic signed [VEL_W-1:0]  new_first_vel_x;
  logic signed [VEL_W-1:0]  new_first_vel_y;
  logic signed [VEL_W-1:0]  new_second_vel_x;
  logic signed [VEL_W-1:0]  new_second_vel_y;

  modport source (
    output valid, contact_status, new_first_pos_x, new_first_pos_y,
           new_second_pos_x, new_second_pos_y, new_first_vel_x, new_first_vel_y,
           new_second_vel_x, new_second_vel_y,
    input  ready
  );
  modport sink (
    input  valid, contact_status, new_first_pos_x, new_first_pos_y,
           new_second_pos_x, new_second_pos_y, new_first_vel_x, new_first_vel_y,
           new_second_vel_x, new_second_vel_y,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/edcr_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side
// payload that travels alongside. No package dependencies.
`default_nettype none

module edcr_sqrt #(
  parameter int QW = 23,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*QW-1:0] x,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [QW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = QW + 3;

  logic [QW-1:0]   vld_q;
  logic [QW-1:0]   root_q [QW];
  logic [SW-1:0]   side_q [QW];
  logic [RW-1:0]   rem_q  [QW-1];
  logic [2*QW-1:0] x_q    [QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [QW-1:0]   root_src;
    logic [SW-1:0]   side_src;
    logic [RW-1:0]   rem_src;
    logic [2*QW-1:0] x_src;
    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nxt;
    logic [QW-1:0]   root_nxt;

    if (s == 0) begin : g_head
      always_comb begin
        root_src = '0;
        side_src = in_side;
        rem_src  = '0;
        x_src    = x;
      end
    end else begin : g_body
      always_comb begin
        root_src = root_q[s-1];
        side_src = side_q[s-1];
        rem_src  = rem_q[s-1];
        x_src    = x_q[s-1];
      end
    end

    // bring down the next two radicand bits, try 4*root+1
    always_comb begin
      rem_sh = {rem_src[RW-3:0], x_src[2*QW-1-2*s -: 2]};
      trial  = RW'({root_src, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_src[QW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_src[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[s] <= root_nxt;
        side_q[s] <= side_src;
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= rem_nxt;
          x_q[s]   <= x_src;
        end
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign root      = root_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

// File: sv/edcr_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, several
// lanes over one shared divisor, with a side payload. No package dependencies.
`default_nettype none

module edcr_div #(
  parameter int LANES = 2,
  parameter int NW    = 32,
  parameter int DW    = 16,
  parameter int QW    = 16,
  parameter int SW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num [LANES],
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quo [LANES],
  output logic [SW-1:0] out_side
);

  localparam int WW = NW + DW;

  logic [QW-1:0] vld_q;
  logic [QW-1:0] quo_q  [QW][LANES];
  logic [SW-1:0] side_q [QW];
  logic [DW-1:0] den_q  [QW-1];
  logic [WW-1:0] rem_q  [QW-1][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QW-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    logic [QW-1:0] quo_src [LANES];
    logic [WW-1:0] rem_src [LANES];
    logic [DW-1:0] den_src;
    logic [SW-1:0] side_src;
    logic [WW-1:0] dsh;
    logic [WW-1:0] rem_nxt [LANES];
    logic [QW-1:0] quo_nxt [LANES];

    if (s == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          quo_src[l] = '0;
          rem_src[l] = WW'(num[l]);
        end
        den_src  = den;
        side_src = in_side;
      end
    end else begin : g_body
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          quo_src[l] = quo_q[s-1][l];
          rem_src[l] = rem_q[s-1][l];
        end
        den_src  = den_q[s-1];
        side_src = side_q[s-1];
      end
    end

    always_comb begin
      dsh = WW'(den_src) << B;
      for (int l = 0; l < LANES; l++) begin
        if (rem_src[l] >= dsh) begin
          rem_nxt[l] = rem_src[l] - dsh;
          quo_nxt[l] = quo_src[l] | (QW'(1) << B);
        end else begin
          rem_nxt[l] = rem_src[l];
          quo_nxt[l] = quo_src[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          quo_q[s][l] <= quo_nxt[l];
        end
        side_q[s] <= side_src;
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem_q[s][l] <= rem_nxt[l];
          end
          den_q[s] <= den_src;
        end
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quo       = quo_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

`default_nettype wire

// File: sv/elastic_disc_collision_resolve_unit.sv
// Elastic collision of two discs: contact test, separation, velocity exchange.
// Depends on edcr_pkg, edcr_ifs, edcr_sqrt, edcr_div and the assertion macros.
//
// Usage:
//   pair   - valid/ready sink, one disc pair per item (positions Q12.12,
//            velocities Q8.12, radii Q10.12, masses Q8.8).
//   result - valid/ready source, one result item per pair: contact status,
//            separated positions and post-collision velocities, saturated.
//   From acceptance to result valid an item passes three setup
//   stages, a 23-stage square root, two stages, a 23-stage divider for the
//   shift and unit normal, six stages, a 26-stage divider for the mass
//   exchange, and four closing stages.
//   Throughput is one item per cycle unless result stalls; every stage holds a valid bit.
//   The whole pipeline advances together. When result is valid and not taken,
//   every stage holds and pair.ready drops in the same cycle; no item is lost
//   or repeated. Bubbles travel as empty slots.
//   Reset (rst, synchronous) empties the pipeline; no result is shown until
//   a new pair is accepted.
`default_nettype none

`include "elastic_disc_collision_resolve_unit_macros.svh"

module elastic_disc_collision_resolve_unit import edcr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  edcr_pair_if.sink     pair,
  edcr_result_if.source result
);

  localparam int SW      = $bits(edcr_item_t);
  localparam int PRODA_W = DIST_W + POS_W;
  localparam int NUMA_W  = PRODA_W;
  localparam int JP_W    = MASS_W + VN_W;
  localparam int NUMB_W  = JP_W + 2;
  localparam int JQ_W    = VN_W + 1;
  localparam int PD_W    = VEL_W + 1 + U_W;
  localparam int DOT_W   = PD_W + 1;
  localparam int PJ_W    = J_W + U_W;
  localparam int RND_W   = 50;
  localparam int LN_SX   = 0;
  localparam int LN_SY   = 1;
  localparam int LN_UX   = 2;
  localparam int LN_UY   = 3;
  localparam int LN_J1   = 0;
  localparam int LN_J2   = 1;
  localparam int POS_HI  = (1 << (POS_W - 1)) - 1;
  localparam int POS_LO  = -(1 << (POS_W - 1));
  localparam int VEL_HI  = (1 << (VEL_W - 1)) - 1;
  localparam int VEL_LO  = -(1 << (VEL_W - 1));
  localparam int U_ONE   = 1 << UNIT_FRAC;

  // divide by 2^20, round to nearest with ties away from zero
  function automatic logic signed [DEL_W-1:0] rnd_frac(input logic signed [RND_W-1:0] v);
    logic [RND_W-1:0] mag;
    logic [DEL_W-1:0] q;
    mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
    q   = DEL_W'((mag + RND_W'(1 << (UNIT_FRAC - 1))) >> UNIT_FRAC);
    return v[RND_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_HI) begin
      r = POS_W'(POS_HI);
    end else if (v < POS_LO) begin
      r = POS_W'(POS_LO);
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [31:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > VEL_HI) begin
      r = VEL_W'(VEL_HI);
    end else if (v < VEL_LO) begin
      r = VEL_W'(VEL_LO);
    end else begin
      r = VEL_W'(v);
    end
    return r;
  endfunction

  logic en;

  logic vld1, vld2, vld3, vld4, vld5, vld6, vld7, vld8, vld9, vld10, vld11;
  logic vld12, vld13, vld14, res_vld;

  edcr_item_t it1, it1_next, it2, it3, it3_next, it4, it4_next, it5, it6, it6_next;
  edcr_item_t it7, it8, it9, it9_next, it10;
  edcr_item_t it11, it12, it12_next, it13, it14;
  edcr_item_t it_sq, it_da, it_db;
  edcr_result_t res, res_next;

  logic [2*D_W-1:0]    dxx2, dyy2;
  logic [SQ_IN_W-1:0]  rs2_2;
  logic [2*D_W-1:0]    d2_sum;
  edcr_status_t        status3;
  logic [SQ_IN_W-1:0]  x3;

  logic                sq_vld;
  logic [DIST_W-1:0]   sq_root;
  logic [SW-1:0]       sq_side;
  logic [DIST_W-1:0]   ov;
  logic signed [D_W-1:0] ndx, ndy;
  logic [POS_W-1:0]    adx, ady, adx4, ady4;
  logic [PRODA_W-1:0]  prod_x4, prod_y4;

  logic [NUMA_W-1:0]   numa5 [4];
  logic [POS_W-1:0]    dena5;
  logic                da_vld;
  logic [DIST_W-1:0]   qa [4];
  logic [SW-1:0]       da_side;

  logic signed [VEL_W:0]   dvx6, dvy6;
  logic signed [PD_W-1:0]  pdx7, pdy7;
  logic signed [DOT_W-1:0] dot8;
  logic [VN_W-1:0]         avn;
  logic [JP_W-1:0]         jp1_10, jp2_10;
  logic [MSUM_W-1:0]       msum;
  logic [NUMB_W-1:0]       numb11 [2];
  logic [MSUM_W-1:0]       denb11;
  logic                    db_vld;
  logic [JQ_W-1:0]         qb [2];
  logic [SW-1:0]           db_side;

  logic signed [PJ_W-1:0]  p1x13, p1y13, p2x13, p2y13;
  logic signed [DEL_W-1:0] d1x14, d1y14, d2x14, d2y14;
  logic                    resolved, massless;

  assign en         = !res_vld || result.ready;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0; vld2 <= 1'b0; vld3 <= 1'b0; vld4 <= 1'b0; vld5 <= 1'b0;
      vld6 <= 1'b0; vld7 <= 1'b0; vld8 <= 1'b0; vld9 <= 1'b0; vld10 <= 1'b0;
      vld11 <= 1'b0; vld12 <= 1'b0; vld13 <= 1'b0; vld14 <= 1'b0;
      res_vld <= 1'b0;
    end else if (en) begin
      vld1 <= pair.valid; vld2 <= vld1; vld3 <= vld2;
      vld4 <= sq_vld; vld5 <= vld4;
      vld6 <= da_vld; vld7 <= vld6; vld8 <= vld7; vld9 <= vld8; vld10 <= vld9;
      vld11 <= vld10;
      vld12 <= db_vld; vld13 <= vld12; vld14 <= vld13;
      res_vld <= vld14;
    end
  end

  // capture and centre difference
  always_comb begin
    it1_next        = '0;
    it1_next.status = ST_NONE;
    it1_next.p1x    = pair.first_pos_x;
    it1_next.p1y    = pair.first_pos_y;
    it1_next.p2x    = pair.second_pos_x;
    it1_next.p2y    = pair.second_pos_y;
    it1_next.v1x    = pair.first_vel_x;
    it1_next.v1y    = pair.first_vel_y;
    it1_next.v2x    = pair.second_vel_x;
    it1_next.v2y    = pair.second_vel_y;
    it1_next.m1     = pair.first_mass;
    it1_next.m2     = pair.second_mass;
    it1_next.rs     = RS_W'(pair.first_radius) + RS_W'(pair.second_radius);
    it1_next.dx     = D_W'(pair.first_pos_x) - D_W'(pair.second_pos_x);
    it1_next.dy     = D_W'(pair.first_pos_y) - D_W'(pair.second_pos_y);
  end

  // contact test
  always_comb begin
    d2_sum = dxx2 + dyy2;
    priority if (d2_sum > (2*D_W)'(rs2_2)) begin
      status3 = ST_NONE;
    end else if (d2_sum == '0) begin
      status3 = ST_COINCIDENT;
    end else begin
      status3 = ST_RESOLVED;
    end
    it3_next        = it2;
    it3_next.status = status3;
  end

  // overlap and shift numerators
  always_comb begin
    it_sq = edcr_item_t'(sq_side);
    ov    = it_sq.rs - sq_root;
    ndx   = it_sq.dx[D_W-1] ? -it_sq.dx : it_sq.dx;
    ndy   = it_sq.dy[D_W-1] ? -it_sq.dy : it_sq.dy;
    adx   = POS_W'(ndx);
    ady   = POS_W'(ndy);
    it4_next          = it_sq;
    it4_next.ctr_dist = sq_root;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1     <= it1_next;
      it2     <= it1;
      dxx2    <= it1.dx * it1.dx;
      dyy2    <= it1.dy * it1.dy;
      rs2_2   <= it1.rs * it1.rs;
      it3     <= it3_next;
      x3      <= d2_sum[SQ_IN_W-1:0];
      it4     <= it4_next;
      prod_x4 <= ov * adx;
      prod_y4 <= ov * ady;
      adx4    <= adx;
      ady4    <= ady;
      it5     <= it4;
      // shifts divide by 2*dist: half the divisor is dist
      numa5[LN_SX] <= prod_x4 + NUMA_W'(it4.ctr_dist);
      numa5[LN_SY] <= prod_y4 + NUMA_W'(it4.ctr_dist);
      // unit normal scaled by two to share the 2*dist divisor
      numa5[LN_UX] <= NUMA_W'({adx4, (UNIT_FRAC + 1)'(0)}) +
                      NUMA_W'({it4.ctr_dist[DIST_W-1:1], 1'b0});
      numa5[LN_UY] <= NUMA_W'({ady4, (UNIT_FRAC + 1)'(0)}) +
                      NUMA_W'({it4.ctr_dist[DIST_W-1:1], 1'b0});
      dena5   <= {it4.ctr_dist, 1'b0};
    end
  end

  edcr_sqrt #(.QW(DIST_W), .SW(SW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld3),
    .x        (x3),
    .in_side  (SW'(it3)),
    .out_valid(sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  edcr_div #(.LANES(4), .NW(NUMA_W), .DW(POS_W), .QW(DIST_W), .SW(SW)) u_div_shift (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld5),
    .num      (numa5),
    .den      (dena5),
    .in_side  (SW'(it5)),
    .out_valid(da_vld),
    .quo      (qa),
    .out_side (da_side)
  );

  // apply signs to shift and unit normal
  always_comb begin
    it_da    = edcr_item_t'(da_side);
    it6_next = it_da;
    it6_next.sx = it_da.dx[D_W-1] ? -$signed(POS_W'(qa[LN_SX])) : $signed(POS_W'(qa[LN_SX]));
    it6_next.sy = it_da.dy[D_W-1] ? -$signed(POS_W'(qa[LN_SY])) : $signed(POS_W'(qa[LN_SY]));
    it6_next.ux = it_da.dx[D_W-1] ? -$signed(U_W'(qa[LN_UX])) : $signed(U_W'(qa[LN_UX]));
    it6_next.uy = it_da.dy[D_W-1] ? -$signed(U_W'(qa[LN_UY])) : $signed(U_W'(qa[LN_UY]));
  end

  always_comb begin
    avn  = VN_W'(it9.vn[VN_W-1] ? -it9.vn : it9.vn);
    msum = MSUM_W'(it10.m1) + MSUM_W'(it10.m2);
    it9_next    = it8;
    it9_next.vn = VN_W'(rnd_frac(RND_W'(dot8)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it6   <= it6_next;
      dvx6  <= (VEL_W + 1)'(it_da.v1x) - (VEL_W + 1)'(it_da.v2x);
      dvy6  <= (VEL_W + 1)'(it_da.v1y) - (VEL_W + 1)'(it_da.v2y);
      it7   <= it6;
      pdx7  <= dvx6 * it6.ux;
      pdy7  <= dvy6 * it6.uy;
      it8   <= it7;
      dot8  <= DOT_W'(pdx7) + DOT_W'(pdy7);
      it9   <= it9_next;
      it10  <= it9;
      jp1_10 <= it9.m2 * avn;
      jp2_10 <= it9.m1 * avn;
      it11  <= it10;
      numb11[LN_J1] <= NUMB_W'({jp1_10, 1'b0}) + NUMB_W'(msum >> 1);
      numb11[LN_J2] <= NUMB_W'({jp2_10, 1'b0}) + NUMB_W'(msum >> 1);
      denb11 <= msum;
    end
  end

  edcr_div #(.LANES(2), .NW(NUMB_W), .DW(MSUM_W), .QW(JQ_W), .SW(SW)) u_div_mass (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vld11),
    .num      (numb11),
    .den      (denb11),
    .in_side  (SW'(it11)),
    .out_valid(db_vld),
    .quo      (qb),
    .out_side (db_side)
  );

  always_comb begin
    it_db     = edcr_item_t'(db_side);
    it12_next = it_db;
    it12_next.j1 = it_db.vn[VN_W-1] ? -$signed(J_W'(qb[LN_J1])) : $signed(J_W'(qb[LN_J1]));
    it12_next.j2 = it_db.vn[VN_W-1] ? -$signed(J_W'(qb[LN_J2])) : $signed(J_W'(qb[LN_J2]));
  end

  // final positions and velocities; items not resolved pass through
  always_comb begin
    resolved = it14.status == ST_RESOLVED;
    massless = (it14.m1 == '0) && (it14.m2 == '0);
    res_next.status = it14.status;
    res_next.n1x = it14.p1x;
    res_next.n1y = it14.p1y;
    res_next.n2x = it14.p2x;
    res_next.n2y = it14.p2y;
    res_next.w1x = it14.v1x;
    res_next.w1y = it14.v1y;
    res_next.w2x = it14.v2x;
    res_next.w2y = it14.v2y;
    if (resolved) begin
      res_next.n1x = sat_pos(32'(it14.p1x) + 32'(it14.sx));
      res_next.n1y = sat_pos(32'(it14.p1y) + 32'(it14.sy));
      res_next.n2x = sat_pos(32'(it14.p2x) - 32'(it14.sx));
      res_next.n2y = sat_pos(32'(it14.p2y) - 32'(it14.sy));
      if (!massless) begin
        res_next.w1x = sat_vel(32'(it14.v1x) - 32'(d1x14));
        res_next.w1y = sat_vel(32'(it14.v1y) - 32'(d1y14));
        res_next.w2x = sat_vel(32'(it14.v2x) + 32'(d2x14));
        res_next.w2y = sat_vel(32'(it14.v2y) + 32'(d2y14));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it12  <= it12_next;
      it13  <= it12;
      p1x13 <= it12.j1 * it12.ux;
      p1y13 <= it12.j1 * it12.uy;
      p2x13 <= it12.j2 * it12.ux;
      p2y13 <= it12.j2 * it12.uy;
      it14  <= it13;
      d1x14 <= rnd_frac(RND_W'(p1x13));
      d1y14 <= rnd_frac(RND_W'(p1y13));
      d2x14 <= rnd_frac(RND_W'(p2x13));
      d2y14 <= rnd_frac(RND_W'(p2y13));
      res   <= res_next;
    end
  end

  assign result.valid            = res_vld;
  assign result.contact_status   = res.status;
  assign result.new_first_pos_x  = res.n1x;
  assign result.new_first_pos_y  = res.n1y;
  assign result.new_second_pos_x = res.n2x;
  assign result.new_second_pos_y = res.n2y;
  assign result.new_first_vel_x  = res.w1x;
  assign result.new_first_vel_y  = res.w1y;
  assign result.new_second_vel_x = res.w2x;
  assign result.new_second_vel_y = res.w2y;

  `EDCR_ASSERT_IMP(a_dist_within_reach, vld4 && it4.status == ST_RESOLVED, it4.ctr_dist <= it4.rs, "contact distance exceeds radius sum")
  `EDCR_ASSERT_IMP(a_unit_bounded, vld6 && it6.status == ST_RESOLVED, (it6.ux <= U_ONE) && (it6.ux >= -U_ONE) && (it6.uy <= U_ONE) && (it6.uy >= -U_ONE), "unit normal out of range")
  `EDCR_ASSERT_NXT(a_stall_freezes, !en, ($stable({vld1, vld6, vld12, res_vld})), "pipeline moved while stalled")
  `EDCR_ASSERT_RST(a_reset_empties, !result.valid && !vld1 && !vld14, "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: tb/sv/elastic_disc_collision_resolve_unit_tb.sv
// Testbench of the disc collision resolver: directed and random disc pairs,
// results predicted in the bench and compared field by field.
// Depends on edcr_pkg, edcr_ifs and the resolver RTL.
`timescale 1ns / 100ps

module elastic_disc_collision_resolve_unit_tb;
  import edcr_pkg::*;

  localparam int PIPE_LAT = 87;

  typedef struct {
    longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, r1, r2, m1, m2;
  } disc_pair_t;

  typedef struct {
    edcr_status_t status;
    longint n1x, n1y, n2x, n2y, w1x, w1y, w2x, w2y;
  } resolved_pair_t;

  logic clk;
  logic rst;
  edcr_pair_if   pair_ch();
  edcr_result_if result_ch();

  elastic_disc_collision_resolve_unit i_dut (
    .clk(clk), .rst(rst), .pair(pair_ch), .result(result_ch)
  );

  resolved_pair_t expected_results[$];
  int  error_count;
  bit  rx_idle_en;
  bit  tx_idle_en;
  bit  rx_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint saturate(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // round to nearest, ties away from zero; den positive
  function automatic longint rnd_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint floor_sqrt(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic resolved_pair_t resolve_collision(disc_pair_t p);
    resolved_pair_t o;
    longint dx, dy, d2, rs, cdist, ov, sx, sy, ux, uy, msum, vn, j1, j2, one;
    one = longint'(1) <<< UNIT_FRAC;
    dx = p.p1x - p.p2x;
    dy = p.p1y - p.p2y;
    d2 = dx * dx + dy * dy;
    rs = p.r1 + p.r2;
    o = '{ST_NONE, p.p1x, p.p1y, p.p2x, p.p2y, p.v1x, p.v1y, p.v2x, p.v2y};
    if (d2 > rs * rs) begin
      o.status = ST_NONE;
    end else if (d2 == 0) begin
      o.status = ST_COINCIDENT;
    end else begin
      o.status = ST_RESOLVED;
      cdist = floor_sqrt(d2);
      ov = rs - cdist;
      sx = rnd_div(ov * dx, 2 * cdist);
      sy = rnd_div(ov * dy, 2 * cdist);
      ux = rnd_div(dx * one, cdist);
      uy = rnd_div(dy * one, cdist);
      o.n1x = p.p1x + sx; o.n1y = p.p1y + sy;
      o.n2x = p.p2x - sx; o.n2y = p.p2y - sy;
      msum = p.m1 + p.m2;
      if (msum > 0) begin
        vn = rnd_div((p.v1x - p.v2x) * ux + (p.v1y - p.v2y) * uy, one);
        j1 = rnd_div(2 * p.m2 * vn, msum);
        j2 = rnd_div(2 * p.m1 * vn, msum);
        o.w1x = p.v1x - rnd_div(j1 * ux, one);
        o.w1y = p.v1y - rnd_div(j1 * uy, one);
        o.w2x = p.v2x + rnd_div(j2 * ux, one);
        o.w2y = p.v2y + rnd_div(j2 * uy, one);
      end
    end
    o.n1x = saturate(o.n1x, POS_W); o.n1y = saturate(o.n1y, POS_W);
    o.n2x = saturate(o.n2x, POS_W); o.n2y = saturate(o.n2y, POS_W);
    o.w1x = saturate(o.w1x, VEL_W); o.w1y = saturate(o.w1y, VEL_W);
    o.w2x = saturate(o.w2x, VEL_W); o.w2y = saturate(o.w2y, VEL_W);
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    error_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // valid stays high after an item; a gap or a drain drops it
  task automatic send_pair(disc_pair_t p);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      pair_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pair_ch.valid        <= 1'b1;
    pair_ch.first_pos_x  <= p.p1x[POS_W-1:0];
    pair_ch.first_pos_y  <= p.p1y[POS_W-1:0];
    pair_ch.second_pos_x <= p.p2x[POS_W-1:0];
    pair_ch.second_pos_y <= p.p2y[POS_W-1:0];
    pair_ch.first_vel_x  <= p.v1x[VEL_W-1:0];
    pair_ch.first_vel_y  <= p.v1y[VEL_W-1:0];
    pair_ch.second_vel_x <= p.v2x[VEL_W-1:0];
    pair_ch.second_vel_y <= p.v2y[VEL_W-1:0];
    pair_ch.first_radius <= p.r1[RAD_W-1:0];
    pair_ch.second_radius <= p.r2[RAD_W-1:0];
    pair_ch.first_mass   <= p.m1[MASS_W-1:0];
    pair_ch.second_mass  <= p.m2[MASS_W-1:0];
    do @(posedge clk); while (!pair_ch.ready);
    expected_results.push_back(resolve_collision(p));
    @(negedge clk);
  endtask

  // result side: sample at rising edge, change ready at falling edge
  initial begin
    resolved_pair_t w;
    int gap;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold) begin
        result_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = expected_results.pop_front();
          if (result_ch.contact_status !== w.status)
            report_mismatch("contact_status", result_ch.contact_status, w.status);
          if (result_ch.new_first_pos_x !== w.n1x[POS_W-1:0])
            report_mismatch("new_first_pos_x", result_ch.new_first_pos_x, w.n1x);
          if (result_ch.new_first_pos_y !== w.n1y[POS_W-1:0])
            report_mismatch("new_first_pos_y", result_ch.new_first_pos_y, w.n1y);
          if (result_ch.new_second_pos_x !== w.n2x[POS_W-1:0])
            report_mismatch("new_second_pos_x", result_ch.new_second_pos_x, w.n2x);
          if (result_ch.new_second_pos_y !== w.n2y[POS_W-1:0])
            report_mismatch("new_second_pos_y", result_ch.new_second_pos_y, w.n2y);
          if (result_ch.new_first_vel_x !== w.w1x[VEL_W-1:0])
            report_mismatch("new_first_vel_x", result_ch.new_first_vel_x, w.w1x);
          if (result_ch.new_first_vel_y !== w.w1y[VEL_W-1:0])
            report_mismatch("new_first_vel_y", result_ch.new_first_vel_y, w.w1y);
          if (result_ch.new_second_vel_x !== w.w2x[VEL_W-1:0])
            report_mismatch("new_second_vel_x", result_ch.new_second_vel_x, w.w2x);
          if (result_ch.new_second_vel_y !== w.w2y[VEL_W-1:0])
            report_mismatch("new_second_vel_y", result_ch.new_second_vel_y, w.w2y);
        end
      end
      @(negedge clk);
    end
  end

  function automatic longint rand_signed(int w);
    longint v;
    v = {$urandom, $urandom};
    v = v & ((longint'(1) <<< w) - 1);
    if (v >= (longint'(1) <<< (w - 1))) v = v - (longint'(1) <<< w);
    return v;
  endfunction

  function automatic longint rand_bits(int w);
    longint v;
    v = {$urandom, $urandom};
    return v & ((longint'(1) <<< w) - 1);
  endfunction

  // mostly touching pairs of moderate size, some wide noise
  function automatic disc_pair_t random_pair();
    disc_pair_t p;
    longint span;
    int kind;
    kind = $urandom_range(0, 9);
    p.v1x = rand_signed(VEL_W); p.v1y = rand_signed(VEL_W);
    p.v2x = rand_signed(VEL_W); p.v2y = rand_signed(VEL_W);
    p.m1 = rand_bits(MASS_W); p.m2 = rand_bits(MASS_W);
    if ($urandom_range(0, 15) == 0) p.m1 = 0;
    if ($urandom_range(0, 15) == 0) p.m2 = 0;
    if (kind < 2) begin
      p.p1x = rand_signed(POS_W); p.p1y = rand_signed(POS_W);
      p.p2x = rand_signed(POS_W); p.p2y = rand_signed(POS_W);
      p.r1 = rand_bits(RAD_W); p.r2 = rand_bits(RAD_W);
    end else begin
      p.r1 = rand_bits($urandom_range(4, RAD_W));
      p.r2 = rand_bits($urandom_range(4, RAD_W));
      span = p.r1 + p.r2 + 1;
      p.p1x = rand_signed(POS_W); p.p1y = rand_signed(POS_W);
      if (kind == 9) begin
        p.p2x = p.p1x; p.p2y = p.p1y;
      end else begin
        p.p2x = saturate(p.p1x + ($urandom % span) - span / 2, POS_W);
        p.p2y = saturate(p.p1y + ($urandom % span) - span / 2, POS_W);
      end
    end
    return p;
  endfunction

  task automatic wait_drained();
    int guard;
    guard = 0;
    pair_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic test_directed();
    disc_pair_t p;
    longint pmax, pmin, vmax, vmin, rmax;
    pmax = (longint'(1) <<< (POS_W - 1)) - 1; pmin = -pmax - 1;
    vmax = (longint'(1) <<< (VEL_W - 1)) - 1; vmin = -vmax - 1;
    rmax = (longint'(1) <<< RAD_W) - 1;
    // head-on touch
    p = '{0, 0, 4096 * 3, 0, 4096, 0, -4096, 0, 4096 * 2, 4096 * 2, 256, 256};
    send_pair(p);
    // far apart, no contact
    p = '{pmin, pmin, pmax, pmax, vmax, vmin, vmin, vmax, 5, 7, 1, 1};
    send_pair(p);
    // coincident centres
    p = '{pmax, pmin, pmax, pmin, vmax, vmax, vmin, vmin, rmax, rmax, 65535, 1};
    send_pair(p);
    // both masses zero: velocities untouched
    p = '{100, 200, 300, 400, 999, -999, 5, 6, 4096, 4096, 0, 0};
    send_pair(p);
    // one mass zero
    p = '{0, 0, 1000, 1000, vmax, vmax, vmin, vmin, 8192, 8192, 0, 65535};
    send_pair(p);
    p = '{0, 0, -1000, 3, vmin, vmax, vmax, vmin, 8192, 8192, 65535, 0};
    send_pair(p);
    // huge overlap near the edges to saturate positions
    p = '{pmax, pmax, pmax - 1, pmax - 1, vmax, vmax, vmin, vmin, rmax, rmax, 1, 65535};
    send_pair(p);
    p = '{pmin, pmin, pmin + 1, pmin, vmin, vmin, vmax, vmax, rmax, rmax, 65535, 65535};
    send_pair(p);
    p = '{pmin, 0, pmax, 0, 0, 0, 0, 0, rmax, rmax, 256, 256};
    send_pair(p);
    // exact touching, zero radii
    p = '{0, 0, 0, 5, 0, 0, 0, 0, 2, 3, 1, 1};
    send_pair(p);
    p = '{1, 1, 0, 0, -1, -1, 1, 1, 0, 0, 1, 1};
    send_pair(p);
    p = '{7, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0};
    send_pair(p);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pair(random_pair());
  endtask

  task automatic test_backpressure();
    int k;
    // receiver blocks while sender keeps offering, filling the pipeline
    rx_hold = 1'b1;
    fork
      begin
        k = 0;
        while (k < 300) begin
          @(negedge clk);
          k++;
        end
        rx_hold = 1'b0;
      end
      repeat (150) send_pair(random_pair());
    join
    // sender pauses until everything has drained
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    rx_hold = 1'b0;
    rst = 1'b1;
    pair_ch.valid = 1'b0;
    pair_ch.first_pos_x = '0; pair_ch.first_pos_y = '0;
    pair_ch.second_pos_x = '0; pair_ch.second_pos_y = '0;
    pair_ch.first_vel_x = '0; pair_ch.first_vel_y = '0;
    pair_ch.second_vel_x = '0; pair_ch.second_vel_y = '0;
    pair_ch.first_radius = '0; pair_ch.second_radius = '0;
    pair_ch.first_mass = '0; pair_ch.second_mass = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_random(500);
    // last part runs with no idling on either side
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(200);
    wait_drained();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (expected_results.size() != 0)
        report_mismatch("results missing", 0, expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
